// ===== hdl/rtc_time_to_seconds_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef RTC_TIME_TO_SECONDS_ASSERT_SVH
`define RTC_TIME_TO_SECONDS_ASSERT_SVH

// Implication that is switched off while reset is high.
`define RTTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication that stays active through reset.
`define RTTS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rtts_pkg.sv =====
`timescale 1ns / 1ps

package rtts_pkg;

   // Field widths.
   localparam int BYTE_W = 8;
   localparam int DAYS_W = 20;
   localparam int T1_W   = 25;
   localparam int T2_W   = 31;
   localparam int SEC_W  = 37;

   // Register map: index taken from paddr bit 2.
   localparam int  CSR_ADDR_W      = 3;
   localparam logic CSR_BINARY_MODE = 1'b0;
   localparam logic CSR_HOUR24_MODE = 1'b1;

   // Days from 0001-01-01 to 2000-01-01.
   localparam logic [DAYS_W-1:0] DAYS_TO_2000 = 20'd730119;

   // Year offsets of the century years 2100 and 2200, which are not leap years.
   localparam logic [BYTE_W-1:0] YEAR_2100_OFS = 8'd100;
   localparam logic [BYTE_W-1:0] YEAR_2200_OFS = 8'd200;

   localparam logic [BYTE_W-1:0] HOUR_NOON   = 8'd12;
   localparam logic [BYTE_W-1:0] MONTH_FIRST = 8'd1;
   localparam logic [BYTE_W-1:0] MONTH_LAST  = 8'd12;
   localparam logic [3:0]        MONTH_FEB   = 4'd2;

   // Input word: one snapshot of the clock registers.
   typedef struct packed {
      logic [BYTE_W-1:0] raw_second;
      logic [BYTE_W-1:0] raw_minute;
      logic [BYTE_W-1:0] raw_hour;
      logic [BYTE_W-1:0] raw_day;
      logic [BYTE_W-1:0] raw_month;
      logic [BYTE_W-1:0] raw_year;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [SEC_W-1:0] seconds_since_epoch;
      logic             valid_res;
   } rsp_word_type;

   // Decoded snapshot after the first front stage.
   typedef struct packed {
      logic [BYTE_W-1:0] second;
      logic [BYTE_W-1:0] minute;
      logic [BYTE_W-1:0] hour;
      logic [BYTE_W-1:0] day;
      logic [3:0]        month;
      logic [BYTE_W-1:0] year;
      logic              ok;
   } decoded_type;

   // Queue entry handed from the front to the back.
   typedef struct packed {
      logic [DAYS_W-1:0] days;
      logic [BYTE_W-1:0] hour;
      logic [BYTE_W-1:0] minute;
      logic [BYTE_W-1:0] second;
      logic              ok;
   } job_type;

   // Two-digit BCD decode: low nibble plus ten times high nibble; binary mode passes the byte through.
   function automatic logic [BYTE_W-1:0] decode_byte(input logic [BYTE_W-1:0] v,
                                                     input logic binary);
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] lo;
      hi = {4'b0, v[7:4]};
      lo = {4'b0, v[3:0]};
      if (binary) begin
         return v;
      end
      return lo + (hi << 3) + (hi << 1);
   endfunction

   // Days in the months before the given month of a common year.
   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/rtts_front.sv =====
`timescale 1ns / 1ps

module rtts_front
   import rtts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type req_data,
   input  logic         binary_mode,
   input  logic         hour24_mode,
   output logic         push,
   output job_type      push_data,
   output logic [1:0]   inflight
);

   logic        a_vld_ff;
   logic        a_vld_in;
   decoded_type a_ff;
   decoded_type a_in;
   logic        b_vld_ff;
   logic        b_vld_in;
   job_type     b_ff;
   job_type     b_in;

   logic [BYTE_W-1:0] mon_dec;
   logic [BYTE_W-1:0] hour_dec;
   logic [16:0]       year_days;
   logic [8:0]        leap_base;
   logic [6:0]        leap_count;
   logic              leap_year;

   // Stage A: decode the bytes, fix up the hour and check month and day.
   always_comb begin
      a_in        = '0;
      mon_dec     = decode_byte(req_data.raw_month, binary_mode);
      hour_dec    = decode_byte({1'b0, req_data.raw_hour[6:0]}, binary_mode);
      if (!hour24_mode) begin
         if (hour_dec == HOUR_NOON) begin
            hour_dec = '0;
         end
         if (req_data.raw_hour[7]) begin
            hour_dec = hour_dec + HOUR_NOON;
         end
      end
      a_in.second = decode_byte(req_data.raw_second, binary_mode);
      a_in.minute = decode_byte(req_data.raw_minute, binary_mode);
      a_in.hour   = hour_dec;
      a_in.day    = decode_byte(req_data.raw_day, binary_mode);
      a_in.month  = mon_dec[3:0];
      a_in.year   = decode_byte(req_data.raw_year, binary_mode);
      a_in.ok     = (mon_dec >= MONTH_FIRST) && (mon_dec <= MONTH_LAST) &&
                    (a_in.day != '0);
      a_vld_in    = accept;
   end

   // Stage B: day count from 0001-01-01, starting from the year 2000.
   always_comb begin
      year_days  = {9'b0, a_ff.year} * 17'd365;
      leap_base  = {1'b0, a_ff.year} + 9'd3;
      leap_count = leap_base[8:2] - {6'b0, a_ff.year > YEAR_2100_OFS}
                                  - {6'b0, a_ff.year > YEAR_2200_OFS};
      leap_year  = (a_ff.year[1:0] == 2'b00) && (a_ff.year != YEAR_2100_OFS) &&
                   (a_ff.year != YEAR_2200_OFS);
      b_in        = '0;
      b_in.days   = DAYS_TO_2000 + {3'b0, year_days} + {13'b0, leap_count}
                  + {11'b0, days_before_month(a_ff.month)}
                  + {19'b0, (a_ff.month > MONTH_FEB) && leap_year}
                  + {12'b0, a_ff.day} - 20'd1;
      b_in.hour   = a_ff.hour;
      b_in.minute = a_ff.minute;
      b_in.second = a_ff.second;
      b_in.ok     = a_ff.ok;
      b_vld_in    = a_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign push      = b_vld_ff;
   assign push_data = b_ff;
   assign inflight  = {1'b0, a_vld_ff} + {1'b0, b_vld_ff};

endmodule

// ===== hdl/rtts_queue.sv =====
`timescale 1ns / 1ps

module rtts_queue
   import rtts_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  job_type                    push_data,
   input  logic                       pop,
   output job_type                    pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   job_type            head_ff;
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   // Pointer and fill-count update; pointers wrap at the last entry.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write, and a registered read of the next head entry. A word
   // written into the slot that becomes the head is passed straight through.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_data;
      end else begin
         head_ff <= mem_ff[rd_ptr_in];
      end
   end

   assign pop_data = head_ff;
   assign count    = count_ff;

endmodule

// ===== hdl/rtts_back.sv =====
`timescale 1ns / 1ps

module rtts_back
   import rtts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_vld,
   input  job_type      job,
   output logic         rsp_valid,
   output rsp_word_type rsp_data
);

   logic              s1_vld_ff;
   logic [T1_W-1:0]   s1_t_ff;
   logic [T1_W-1:0]   s1_t_in;
   logic [BYTE_W-1:0] s1_min_ff;
   logic [BYTE_W-1:0] s1_sec_ff;
   logic              s1_ok_ff;
   logic              s2_vld_ff;
   logic [T2_W-1:0]   s2_t_ff;
   logic [T2_W-1:0]   s2_t_in;
   logic [BYTE_W-1:0] s2_sec_ff;
   logic              s2_ok_ff;
   logic              s3_vld_ff;
   rsp_word_type      s3_ff;
   rsp_word_type      s3_in;

   // Days to hours, hours to minutes, minutes to seconds: one multiply per stage.
   always_comb begin
      s1_t_in = T1_W'(job.days) * T1_W'(24) + T1_W'(job.hour);
      s2_t_in = T2_W'(s1_t_ff) * T2_W'(60) + T2_W'(s1_min_ff);
      s3_in.valid_res = s2_ok_ff;
      if (s2_ok_ff) begin
         s3_in.seconds_since_epoch = SEC_W'(s2_t_ff) * SEC_W'(60) + SEC_W'(s2_sec_ff);
      end else begin
         s3_in.seconds_since_epoch = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= job_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_t_ff   <= s1_t_in;
      s1_min_ff <= job.minute;
      s1_sec_ff <= job.second;
      s1_ok_ff  <= job.ok;
      s2_t_ff   <= s2_t_in;
      s2_sec_ff <= s1_sec_ff;
      s2_ok_ff  <= s1_ok_ff;
      s3_ff     <= s3_in;
   end

   assign rsp_valid = s3_vld_ff;
   assign rsp_data  = s3_ff;

endmodule

// ===== hdl/rtc_time_to_seconds.sv =====
`timescale 1ns / 1ps

// Channel    | Ports                                    | Transfer
// -----------+------------------------------------------+--------------------------------
// request    | start, busy, req_data                    | start high while busy is low
// response   | rsp_valid, rsp_data                      | rsp_valid high for one cycle
// registers  | psel, penable, pwrite, paddr, pwdata,    | write at access cycle,
//            | prdata, pready                           | pready always high
//
// One word is taken every cycle while busy is low; its result passes through
// two front stages (decode, day count), one queue slot and
// three back stages, one multiply each (days to hours, minutes, seconds).
// busy rises only when the queue could not take what is still in the front.
// The response side cannot stall; the back drains the queue every cycle.
// Synchronous reset clears both mode registers and drops words in flight.

module rtc_time_to_seconds
   import rtts_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic             binary_mode_ff;
   logic             binary_mode_in;
   logic             hour24_mode_ff;
   logic             hour24_mode_in;
   logic             csr_write;
   logic             accept;
   logic             push;
   job_type          push_data;
   logic [1:0]       inflight;
   logic [CNT_W-1:0] q_count;
   logic [CNT_W:0]   q_credit;
   logic             pop;
   job_type          pop_data;

   // Register writes.
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      binary_mode_in = binary_mode_ff;
      hour24_mode_in = hour24_mode_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_BINARY_MODE: binary_mode_in = pwdata[0];
            CSR_HOUR24_MODE: hour24_mode_in = pwdata[0];
            default:         binary_mode_in = binary_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         binary_mode_ff <= 1'b0;
         hour24_mode_ff <= 1'b0;
      end else begin
         binary_mode_ff <= binary_mode_in;
         hour24_mode_ff <= hour24_mode_in;
      end
   end

   // Register reads.
   always_comb begin
      case (paddr[2])
         CSR_BINARY_MODE: prdata = {31'b0, binary_mode_ff};
         CSR_HOUR24_MODE: prdata = {31'b0, hour24_mode_ff};
         default:         prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // Hold off new words when the queue could not absorb the front's contents.
   assign q_credit = {1'b0, q_count} + (CNT_W + 1)'(inflight);
   assign busy     = q_credit >= (CNT_W + 1)'(QUEUE_DEPTH);
   assign accept   = start && !busy;

   rtts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .binary_mode (binary_mode_ff),
      .hour24_mode (hour24_mode_ff),
      .push        (push),
      .push_data   (push_data),
      .inflight    (inflight)
   );

   rtts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .count     (q_count)
   );

   // The back never stalls, so it takes the head word whenever there is one.
   assign pop = q_count != '0;

   rtts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_vld   (pop),
      .job       (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/rtts_checker.sv =====
`timescale 1ns / 1ps
`include "rtc_time_to_seconds_assert.svh"

module rtts_checker
   import rtts_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_word_type rsp_data
);

   // Seconds at 2000-01-01 00:00:00, the earliest date the year field can give.
   localparam logic [SEC_W-1:0] MIN_VALID_SECONDS = 37'd63082281600;

   // Every accepted word yields exactly one result, and every result stems from an accepted word.
   `RTTS_ASSERT_IMPLY(a_accept_to_rsp, clock, reset, start && !busy, 1'b1 ##6 rsp_valid, "accepted word produced no result")
   `RTTS_ASSERT_IMPLY(a_rsp_from_accept, clock, reset, rsp_valid, $past(start && !busy, 6), "result without an accepted word")

   // A rejected date reports zero seconds; a valid one is no earlier than 2000.
   `RTTS_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_valid && !rsp_data.valid_res, rsp_data.seconds_since_epoch == '0, "invalid date with nonzero seconds")
   `RTTS_ASSERT_IMPLY(a_valid_range, clock, reset, rsp_valid && rsp_data.valid_res, rsp_data.seconds_since_epoch >= MIN_VALID_SECONDS, "valid result before year 2000")

   // Reset flushes the pipeline.
   `RTTS_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid, "result right after reset")

endmodule

bind rtc_time_to_seconds rtts_checker u_rtts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
